/* hw/rtl/bcs_pkg.sv */
// ----------------------------------------------------------------------------
// Button calibration sequencer package
// Shared widths, phase and blink codes, register indexes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bcs_pkg;

  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int LEVEL_W = 12;
  localparam int CH_W    = 3;
  localparam int NUM_IN_CH = 8;
  localparam int IDX_W   = 2;

  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd2000;
  localparam logic [CFG_W-1:0] MAX_HOLD_RST   = 16'd5000;
  localparam logic [CFG_W-1:0] CONFIRM_RST    = 16'd1000;

  localparam logic [IDX_W-1:0] REG_LONG_PRESS = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAX_HOLD   = 2'd1;
  localparam logic [IDX_W-1:0] REG_CONFIRM    = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_WAIT_REL   = 3'd1,
    PH_BLACK      = 3'd2,
    PH_BLACK_CONF = 3'd3,
    PH_WHITE      = 3'd4,
    PH_WHITE_CONF = 3'd5,
    PH_ERROR      = 3'd6,
    PH_DISABLED   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    BL_OFF  = 2'd0,
    BL_FAST = 2'd1,
    BL_SLOW = 2'd2
  } blink_t;

  typedef enum logic [1:0] {
    THR_LONG    = 2'd0,
    THR_HOLD    = 2'd1,
    THR_CONFIRM = 2'd2
  } thr_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     base_pstart;
    thr_sel_t thr_sel;
    logic     set_mark;
    logic     cap_black;
    logic     cap_white;
    logic     out_load;
    logic     out_cal;
    logic     out_last;
    phase_t   out_phase;
    blink_t   out_blink;
    logic     out_err;
  } dp_cmd_t;

  typedef struct packed {
    logic key_down;
    logic press_evt;
    logic time_ge;
  } dp_stat_t;

  typedef struct packed {
    phase_t             phase;
    blink_t             blink;
    logic               err;
    logic               cal;
    logic [CH_W-1:0]    channel;
    logic [LEVEL_W-1:0] black;
    logic [LEVEL_W-1:0] white;
    logic               last;
  } result_t;

endpackage

/* hw/rtl/bcs_in_if.sv */
// ----------------------------------------------------------------------------
// Tick channel
// One millisecond tick: time stamps, key state and one sample per channel.
// ----------------------------------------------------------------------------
interface bcs_in_if;
  logic                         valid;
  logic                         ready;
  logic [bcs_pkg::TIME_W-1:0]   now_ms;
  logic [bcs_pkg::TIME_W-1:0]   press_start_ms;
  logic                         key_down;
  logic                         press_event;
  logic [bcs_pkg::LEVEL_W-1:0]  sample_ch0;
  logic [bcs_pkg::LEVEL_W-1:0]  sample_ch1;
  logic [bcs_pkg::LEVEL_W-1:0]  sample_ch2;
  logic [bcs_pkg::LEVEL_W-1:0]  sample_ch3;
  logic [bcs_pkg::LEVEL_W-1:0]  sample_ch4;
  logic [bcs_pkg::LEVEL_W-1:0]  sample_ch5;
  logic [bcs_pkg::LEVEL_W-1:0]  sample_ch6;
  logic [bcs_pkg::LEVEL_W-1:0]  sample_ch7;

  modport source (
    output valid, now_ms, press_start_ms, key_down, press_event,
           sample_ch0, sample_ch1, sample_ch2, sample_ch3,
           sample_ch4, sample_ch5, sample_ch6, sample_ch7,
    input  ready
  );
  modport sink (
    input  valid, now_ms, press_start_ms, key_down, press_event,
           sample_ch0, sample_ch1, sample_ch2, sample_ch3,
           sample_ch4, sample_ch5, sample_ch6, sample_ch7,
    output ready
  );
endinterface

/* hw/rtl/bcs_out_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Status of the sequencer and, after a white capture, calibration pairs.
// ----------------------------------------------------------------------------
interface bcs_out_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   phase;
  logic [1:0]                   blink_mode;
  logic                         stuck_error;
  logic                         cal_valid;
  logic [bcs_pkg::CH_W-1:0]     channel;
  logic [bcs_pkg::LEVEL_W-1:0]  black_level;
  logic [bcs_pkg::LEVEL_W-1:0]  white_level;
  logic                         last;

  modport source (
    output valid, phase, blink_mode, stuck_error, cal_valid, channel,
           black_level, white_level, last,
    input  ready
  );
  modport sink (
    input  valid, phase, blink_mode, stuck_error, cal_valid, channel,
           black_level, white_level, last,
    output ready
  );
endinterface

/* hw/rtl/bcs_ctrl.sv */
// ----------------------------------------------------------------------------
// Sequencer controller
// Holds the calibration phase, blink mode, error latch and pending press, and
// steps each tick through evaluate, load and send.
// ----------------------------------------------------------------------------
module bcs_ctrl #(
  parameter int CHANNELS = 8,
  localparam int CNT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick_valid,
  output logic               tick_ready,
  output logic               res_valid,
  input  logic               res_ready,
  input  bcs_pkg::dp_stat_t  stat,
  output bcs_pkg::dp_cmd_t   cmd,
  output logic [CNT_W-1:0]   chan
);
  import bcs_pkg::*;

  localparam logic [CNT_W-1:0] LAST_CH = CNT_W'(CHANNELS - 1);

  typedef enum logic [1:0] {
    C_IDLE,
    C_EVAL,
    C_LOAD,
    C_SEND
  } ctrl_state_t;

  ctrl_state_t      state;
  phase_t           phase;
  blink_t           blink;
  logic             err;
  logic             pending;
  logic             cal;
  logic [CNT_W-1:0] cnt;

  phase_t phase_next;
  blink_t blink_next;
  logic   err_next;
  logic   pending_next;
  logic   cal_next;
  logic   pend_eff;
  logic   set_mark;
  logic   cap_black;
  logic   cap_white;
  logic   more;

  // A press edge on this tick counts before the transition is evaluated.
  assign pend_eff = pending | stat.press_evt;
  assign more     = cal && (cnt != LAST_CH);

  always_comb begin
    phase_next   = phase;
    blink_next   = blink;
    err_next     = err;
    pending_next = pend_eff;
    cal_next     = 1'b0;
    set_mark     = 1'b0;
    cap_black    = 1'b0;
    cap_white    = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (pend_eff && stat.time_ge && stat.key_down) begin
          blink_next = BL_FAST;
          phase_next = PH_WAIT_REL;
          set_mark   = 1'b1;
        end
      end
      PH_WAIT_REL: begin
        if (stat.key_down) begin
          if (stat.time_ge) begin
            phase_next = PH_ERROR;
          end
        end else begin
          blink_next = BL_SLOW;
          phase_next = PH_BLACK;
        end
      end
      PH_BLACK: begin
        if (pend_eff) begin
          pending_next = 1'b0;
          if (stat.key_down) begin
            cap_black  = 1'b1;
            blink_next = BL_FAST;
            phase_next = PH_BLACK_CONF;
            set_mark   = 1'b1;
          end
        end
      end
      PH_BLACK_CONF: begin
        if (stat.time_ge) begin
          blink_next = BL_SLOW;
          phase_next = PH_WHITE;
        end
      end
      PH_WHITE: begin
        if (pend_eff) begin
          pending_next = 1'b0;
          if (stat.key_down) begin
            cap_white  = 1'b1;
            blink_next = BL_FAST;
            phase_next = PH_WHITE_CONF;
            set_mark   = 1'b1;
            cal_next   = 1'b1;
          end
        end
      end
      PH_WHITE_CONF: begin
        if (stat.time_ge) begin
          blink_next = BL_OFF;
          phase_next = PH_IDLE;
        end
      end
      PH_ERROR: begin
        blink_next = BL_OFF;
        err_next   = 1'b1;
        phase_next = PH_DISABLED;
      end
      PH_DISABLED: begin
        phase_next = PH_DISABLED;
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  always_comb begin
    tick_ready = (state == C_IDLE);
    res_valid  = (state == C_SEND);
    chan       = (state == C_SEND) ? CNT_W'(cnt + 1'b1) : cnt;

    cmd             = '0;
    cmd.load_in     = (state == C_IDLE) && tick_valid;
    cmd.base_pstart = (phase == PH_IDLE);
    if (phase == PH_IDLE) begin
      cmd.thr_sel = THR_LONG;
    end else if (phase == PH_WAIT_REL) begin
      cmd.thr_sel = THR_HOLD;
    end else begin
      cmd.thr_sel = THR_CONFIRM;
    end
    cmd.set_mark  = (state == C_EVAL) && set_mark;
    cmd.cap_black = (state == C_EVAL) && cap_black;
    cmd.cap_white = (state == C_EVAL) && cap_white;
    cmd.out_load  = (state == C_LOAD) || ((state == C_SEND) && res_ready && more);
    cmd.out_cal   = cal;
    cmd.out_last  = cal ? (chan == LAST_CH) : 1'b1;
    cmd.out_phase = phase;
    cmd.out_blink = blink;
    cmd.out_err   = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= C_IDLE;
      phase   <= PH_IDLE;
      blink   <= BL_OFF;
      err     <= 1'b0;
      pending <= 1'b0;
      cal     <= 1'b0;
      cnt     <= '0;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (tick_valid) begin
            state <= C_EVAL;
          end
        end
        C_EVAL: begin
          phase   <= phase_next;
          blink   <= blink_next;
          err     <= err_next;
          pending <= pending_next;
          cal     <= cal_next;
          cnt     <= '0;
          state   <= C_LOAD;
        end
        C_LOAD: begin
          state <= C_SEND;
        end
        C_SEND: begin
          if (res_ready) begin
            if (more) begin
              cnt <= CNT_W'(cnt + 1'b1);
            end else begin
              state <= C_IDLE;
            end
          end
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/bcs_dp.sv */
// ----------------------------------------------------------------------------
// Sequencer datapath
// Tick registers, timing compare, configuration, black and white level
// stores and the result register.
// ----------------------------------------------------------------------------
module bcs_dp #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 12,
  localparam int CNT_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int STORE_W = (SAMPLE_BITS < bcs_pkg::LEVEL_W) ? SAMPLE_BITS : bcs_pkg::LEVEL_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bcs_pkg::IDX_W-1:0]    cfg_index,
  input  logic [bcs_pkg::CFG_W-1:0]    cfg_data,
  input  logic [bcs_pkg::TIME_W-1:0]   now_ms,
  input  logic [bcs_pkg::TIME_W-1:0]   press_start_ms,
  input  logic                         key_down,
  input  logic                         press_event,
  input  logic [bcs_pkg::LEVEL_W-1:0]  samples [CHANNELS],
  input  bcs_pkg::dp_cmd_t             cmd,
  input  logic [CNT_W-1:0]             chan,
  output bcs_pkg::dp_stat_t            stat,
  output bcs_pkg::result_t             res
);
  import bcs_pkg::*;

  logic [CFG_W-1:0]   long_press_ms;
  logic [CFG_W-1:0]   max_hold_ms;
  logic [CFG_W-1:0]   confirm_ms;

  logic [TIME_W-1:0]  now_r;
  logic [TIME_W-1:0]  pstart_r;
  logic               down_r;
  logic               evt_r;
  logic [STORE_W-1:0] samp_r [CHANNELS];
  logic [TIME_W-1:0]  mark_time;

  logic [STORE_W-1:0] black_store [CHANNELS];
  logic [STORE_W-1:0] white_store [CHANNELS];

  logic [TIME_W-1:0]  base;
  logic [TIME_W-1:0]  elapsed;
  logic [CFG_W-1:0]   thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= LONG_PRESS_RST;
      max_hold_ms   <= MAX_HOLD_RST;
      confirm_ms    <= CONFIRM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LONG_PRESS: long_press_ms <= cfg_data;
        REG_MAX_HOLD:   max_hold_ms   <= cfg_data;
        REG_CONFIRM:    confirm_ms    <= cfg_data;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      now_r    <= now_ms;
      pstart_r <= press_start_ms;
      down_r   <= key_down;
      evt_r    <= press_event;
      for (int i = 0; i < CHANNELS; i++) begin
        samp_r[i] <= samples[i][STORE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_time <= '0;
    end else if (cmd.set_mark) begin
      mark_time <= now_r;
    end
  end

  always_comb begin
    unique case (cmd.thr_sel)
      THR_LONG: thr = long_press_ms;
      THR_HOLD: thr = max_hold_ms;
      default:  thr = confirm_ms;
    endcase
  end

  // Elapsed time is taken modulo 2^32, so a wrapped clock still compares right.
  assign base    = cmd.base_pstart ? pstart_r : mark_time;
  assign elapsed = now_r - base;

  assign stat.key_down  = down_r;
  assign stat.press_evt = evt_r;
  assign stat.time_ge   = (elapsed >= TIME_W'(thr));

  // On the white capture each pair is ordered so that white is never below black.
  always_ff @(posedge clk) begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (cmd.cap_black) begin
        black_store[i] <= samp_r[i];
      end else if (cmd.cap_white) begin
        if (samp_r[i] < black_store[i]) begin
          white_store[i] <= black_store[i];
          black_store[i] <= samp_r[i];
        end else begin
          white_store[i] <= samp_r[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res.phase <= cmd.out_phase;
      res.blink <= cmd.out_blink;
      res.err   <= cmd.out_err;
      res.cal   <= cmd.out_cal;
      res.last  <= cmd.out_last;
      if (cmd.out_cal) begin
        res.channel <= CH_W'(chan);
        res.black   <= LEVEL_W'(black_store[chan]);
        res.white   <= LEVEL_W'(white_store[chan]);
      end else begin
        res.channel <= '0;
        res.black   <= '0;
        res.white   <= '0;
      end
    end
  end

endmodule

/* hw/rtl/button_calibration_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// Button calibration sequencer
// One-button black and white calibration for a multi-channel line sensor.
// ----------------------------------------------------------------------------
// Usage: each beat on the tick channel is one millisecond tick carrying the
// time, the press start time, the debounced key level, a press edge flag and
// the channel samples. The result channel returns one status beat per tick,
// or, on the tick that captures white levels, CHANNELS beats carrying the
// ordered black and white pair of each channel, with last on the final one.
// Registers are written through cfg_we, cfg_index and cfg_data while idle.
// Timing: a tick is taken, evaluated in the next cycle, and its first result
// is registered in the cycle after that; a tick passes through the idle,
// evaluate, load and send states before the earliest next tick is taken, and
// a calibration tick stays in send for each of its CHANNELS beats. The
// controller handles one tick at a time; the result register paces the
// calibration beats at one per cycle while the receiver holds ready high.
// Reset: the sequencer returns to idle with blinking off, the error cleared
// and the registers at their defaults; the level stores keep no reset.
// Stall: while the receiver holds ready low the result beat is held and no
// new tick is taken.
// ----------------------------------------------------------------------------
module button_calibration_sequencer_unit #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bcs_pkg::IDX_W-1:0]  cfg_index,
  input  logic [bcs_pkg::CFG_W-1:0]  cfg_data,
  bcs_in_if.sink                     tick,
  bcs_out_if.source                  result
);
  import bcs_pkg::*;

  localparam int CNT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  result_t            res;
  logic [CNT_W-1:0]   chan;
  logic [LEVEL_W-1:0] all_samples [NUM_IN_CH];
  logic [LEVEL_W-1:0] samples [CHANNELS];

  assign all_samples[0] = tick.sample_ch0;
  assign all_samples[1] = tick.sample_ch1;
  assign all_samples[2] = tick.sample_ch2;
  assign all_samples[3] = tick.sample_ch3;
  assign all_samples[4] = tick.sample_ch4;
  assign all_samples[5] = tick.sample_ch5;
  assign all_samples[6] = tick.sample_ch6;
  assign all_samples[7] = tick.sample_ch7;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_samp
    assign samples[g] = all_samples[g];
  end

  bcs_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick.valid),
    .tick_ready (tick.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .stat       (stat),
    .cmd        (cmd),
    .chan       (chan)
  );

  bcs_dp #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .now_ms         (tick.now_ms),
    .press_start_ms (tick.press_start_ms),
    .key_down       (tick.key_down),
    .press_event    (tick.press_event),
    .samples        (samples),
    .cmd            (cmd),
    .chan           (chan),
    .stat           (stat),
    .res            (res)
  );

  assign result.phase       = res.phase;
  assign result.blink_mode  = res.blink;
  assign result.stuck_error = res.err;
  assign result.cal_valid   = res.cal;
  assign result.channel     = res.channel;
  assign result.black_level = res.black;
  assign result.white_level = res.white;
  assign result.last        = res.last;

`ifndef SYNTH
  // A tick is never taken while a result beat is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(tick.ready && result.valid))
    else $error("tick taken while a result beat is pending");

  // Once the final beat of a tick is taken the block is ready for the next tick.
  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready && result.last |=> tick.ready)
    else $error("not ready after the final result beat");

  // Calibration pairs are always ordered.
  a_pair_ordered: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.cal_valid |-> result.white_level >= result.black_level)
    else $error("calibration pair out of order");

  // A status beat is always the only beat of its tick.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.cal_valid |-> result.last)
    else $error("status beat without last");
`endif

endmodule

/* dv/tb_button_calibration_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// Button calibration sequencer testbench
// Sends millisecond ticks to the sequencer and checks every result beat
// against a behavioural model of the calibration flow kept in this module.
// A directed pass walks one full black and white calibration with edge
// values, random passes run sequences under several threshold settings, and
// a closing pass provokes the stuck-key error that disables the block.
// ----------------------------------------------------------------------------
module tb_button_calibration_sequencer_unit;
  import bcs_pkg::*;

  localparam int NCH = NUM_IN_CH;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [TIME_W-1:0]            now;
    logic [TIME_W-1:0]            pstart;
    logic                         down;
    logic                         pevt;
    logic [NCH-1:0][LEVEL_W-1:0]  samp;
  } tick_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bcs_in_if  tick_bus ();
  bcs_out_if res_bus ();

  button_calibration_sequencer_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_bus),
    .result    (res_bus)
  );

  always #6 clk = ~clk;

  // Model of the sequencer and its thresholds.
  phase_t             cur_phase;
  blink_t             cur_blink;
  logic               stuck_flag;
  logic               pend_press;
  logic [TIME_W-1:0]  mark_ms;
  logic [LEVEL_W-1:0] black_lvl [NCH];
  logic [LEVEL_W-1:0] white_lvl [NCH];
  logic [CFG_W-1:0]   long_ms;
  logic [CFG_W-1:0]   hold_ms;
  logic [CFG_W-1:0]   confirm_ms;

  result_t     beats_due [$];
  int unsigned mismatches = 0;
  bit          idling_on = 1'b1;

  function automatic void advance_sequencer(input tick_t t);
    logic [TIME_W-1:0]  held;
    logic [TIME_W-1:0]  since_mark;
    logic [LEVEL_W-1:0] w;
    logic               white_done;
    result_t            r;
    held = t.now - t.pstart;
    since_mark = t.now - mark_ms;
    white_done = 1'b0;
    if (t.pevt) pend_press = 1'b1;
    case (cur_phase)
      PH_IDLE: begin
        // The arming press stays pending and is consumed in the black phase.
        if (pend_press && t.down && held >= {16'd0, long_ms}) begin
          cur_blink = BL_FAST;
          cur_phase = PH_WAIT_REL;
          mark_ms = t.now;
        end
      end
      PH_WAIT_REL: begin
        if (t.down) begin
          if (since_mark >= {16'd0, hold_ms}) cur_phase = PH_ERROR;
        end else begin
          cur_blink = BL_SLOW;
          cur_phase = PH_BLACK;
        end
      end
      PH_BLACK: begin
        if (pend_press) begin
          pend_press = 1'b0;
          if (t.down) begin
            for (int c = 0; c < NCH; c++) black_lvl[c] = t.samp[c];
            cur_blink = BL_FAST;
            cur_phase = PH_BLACK_CONF;
            mark_ms = t.now;
          end
        end
      end
      PH_BLACK_CONF: begin
        if (since_mark >= {16'd0, confirm_ms}) begin
          cur_blink = BL_SLOW;
          cur_phase = PH_WHITE;
        end
      end
      PH_WHITE: begin
        if (pend_press) begin
          pend_press = 1'b0;
          if (t.down) begin
            for (int c = 0; c < NCH; c++) begin
              w = t.samp[c];
              if (w < black_lvl[c]) begin
                white_lvl[c] = black_lvl[c];
                black_lvl[c] = w;
              end else begin
                white_lvl[c] = w;
              end
            end
            cur_blink = BL_FAST;
            cur_phase = PH_WHITE_CONF;
            mark_ms = t.now;
            white_done = 1'b1;
          end
        end
      end
      PH_WHITE_CONF: begin
        if (since_mark >= {16'd0, confirm_ms}) begin
          cur_blink = BL_OFF;
          cur_phase = PH_IDLE;
        end
      end
      PH_ERROR: begin
        cur_blink = BL_OFF;
        stuck_flag = 1'b1;
        cur_phase = PH_DISABLED;
      end
      default: ;
    endcase
    r.phase = cur_phase;
    r.blink = cur_blink;
    r.err = stuck_flag;
    if (white_done) begin
      for (int c = 0; c < NCH; c++) begin
        r.cal = 1'b1;
        r.channel = CH_W'(c);
        r.black = black_lvl[c];
        r.white = white_lvl[c];
        r.last = (c == NCH - 1);
        beats_due.push_back(r);
      end
    end else begin
      r.cal = 1'b0;
      r.channel = '0;
      r.black = '0;
      r.white = '0;
      r.last = 1'b1;
      beats_due.push_back(r);
    end
  endfunction

  function automatic tick_t make_tick(input logic [TIME_W-1:0] now, pstart,
                                      input logic down, pevt);
    tick_t       t;
    int unsigned pick;
    t.now = now;
    t.pstart = pstart;
    t.down = down;
    t.pevt = pevt;
    for (int c = 0; c < NCH; c++) begin
      pick = $urandom_range(0, 7);
      if (pick == 0) t.samp[c] = '0;
      else if (pick == 1) t.samp[c] = '1;
      else t.samp[c] = LEVEL_W'($urandom_range(0, (1 << LEVEL_W) - 1));
    end
    return t;
  endfunction

  // Mostly lands on or just past the threshold, sometimes short of it.
  function automatic logic [TIME_W-1:0] offset_around(input logic [CFG_W-1:0] thr);
    if (thr == 0 || $urandom_range(0, 2) != 0) return thr + $urandom_range(0, 3);
    return $urandom_range(0, thr - 1);
  endfunction

  // Ticks are shaped by the modelled phase so that most of them move the
  // calibration on; holds while waiting for release never reach the
  // stuck-key time, which is left to the closing test.
  function automatic tick_t random_tick();
    tick_t       t;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    t = make_tick($urandom, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    case (cur_phase)
      PH_IDLE: begin
        if (roll < 80) begin
          t.pevt = (roll < 65);
          t.down = (roll % 7 != 0);
          t.now = t.pstart + offset_around(long_ms);
        end
      end
      PH_WAIT_REL: begin
        if (hold_ms == 0 || roll < 65) begin
          t.down = 1'b0;
        end else begin
          t.down = 1'b1;
          t.now = mark_ms + $urandom_range(0, hold_ms - 1);
        end
      end
      PH_BLACK, PH_WHITE: begin
        t.pevt = (roll < 50);
        t.down = ($urandom_range(0, 9) < 7);
      end
      PH_BLACK_CONF, PH_WHITE_CONF: begin
        if (roll < 85) t.now = mark_ms + offset_around(confirm_ms);
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic send_tick(input tick_t t);
    tick_bus.valid          <= 1'b1;
    tick_bus.now_ms         <= t.now;
    tick_bus.press_start_ms <= t.pstart;
    tick_bus.key_down       <= t.down;
    tick_bus.press_event    <= t.pevt;
    tick_bus.sample_ch0     <= t.samp[0];
    tick_bus.sample_ch1     <= t.samp[1];
    tick_bus.sample_ch2     <= t.samp[2];
    tick_bus.sample_ch3     <= t.samp[3];
    tick_bus.sample_ch4     <= t.samp[4];
    tick_bus.sample_ch5     <= t.samp[5];
    tick_bus.sample_ch6     <= t.samp[6];
    tick_bus.sample_ch7     <= t.samp[7];
    @(posedge clk);
    while (!tick_bus.ready) @(posedge clk);
    advance_sequencer(t);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      tick_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    tick_bus.valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_thresholds(input logic [CFG_W-1:0] lp, hd, cf);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_LONG_PRESS;
    cfg_data  <= lp;
    @(posedge clk);
    cfg_index <= REG_MAX_HOLD;
    cfg_data  <= hd;
    @(posedge clk);
    cfg_index <= REG_CONFIRM;
    cfg_data  <= cf;
    @(posedge clk);
    cfg_we <= 1'b0;
    long_ms = lp;
    hold_ms = hd;
    confirm_ms = cf;
  endtask

  // One full calibration at the reset thresholds, with time wrapping round
  // during the arming press and alternating extreme samples.
  task automatic test_directed_calibration();
    tick_t             t;
    logic [TIME_W-1:0] base;
    t = make_tick(32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0);
    t.samp = '1;
    send_tick(t);
    t = make_tick(32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0);
    t.samp = '0;
    send_tick(t);
    base = 32'hFFFF_F900;
    send_tick(make_tick(base + 32'd1999, base, 1'b1, 1'b1));
    send_tick(make_tick(base + 32'd2000, base, 1'b1, 1'b0));
    send_tick(make_tick(mark_ms + 32'd10, base, 1'b1, 1'b0));
    send_tick(make_tick(mark_ms + 32'd20, base, 1'b0, 1'b0));
    // The arming press is still pending and is used up with the key released.
    send_tick(make_tick(mark_ms + 32'd21, base, 1'b0, 1'b0));
    t = make_tick(mark_ms + 32'd22, base, 1'b1, 1'b1);
    for (int c = 0; c < NCH; c++) t.samp[c] = c[0] ? 12'hFFF : 12'h000;
    t.samp[6] = 12'h5A5;
    send_tick(t);
    send_tick(make_tick(mark_ms + 32'd999, base, 1'b0, 1'b0));
    send_tick(make_tick(mark_ms + 32'd1000, base, 1'b0, 1'b0));
    send_tick(make_tick(mark_ms + 32'd1500, base, 1'b0, 1'b1));
    send_tick(make_tick(mark_ms + 32'd1501, base, 1'b1, 1'b0));
    // Odd channels go from full scale to zero, so their pairs are swapped.
    t = make_tick(mark_ms + 32'd1502, base, 1'b1, 1'b1);
    for (int c = 0; c < NCH; c++) t.samp[c] = c[0] ? 12'h000 : 12'hFFF;
    t.samp[6] = 12'h5A5;
    send_tick(t);
    send_tick(make_tick(mark_ms + 32'd999, base, 1'b1, 1'b0));
    send_tick(make_tick(mark_ms + 32'd1000, base, 1'b0, 1'b0));
  endtask

  task automatic test_random_sequences(input int unsigned count,
                                       input logic [CFG_W-1:0] lp, hd, cf);
    program_thresholds(lp, hd, cf);
    repeat (count) begin
      send_tick(random_tick());
      if ($urandom_range(0, 49) == 0) wait_drained();
    end
  endtask

  // With a zero hold time the first held tick after arming is a stuck key;
  // the block then stays disabled and ignores every further press.
  task automatic test_stuck_key();
    logic [TIME_W-1:0] start;
    program_thresholds(16'd3, 16'd0, 16'd2);
    while (cur_phase != PH_IDLE && cur_phase != PH_ERROR && cur_phase != PH_DISABLED) begin
      case (cur_phase)
        PH_BLACK_CONF, PH_WHITE_CONF:
          send_tick(make_tick(mark_ms + confirm_ms, 32'h0, 1'b0, 1'b0));
        PH_BLACK, PH_WHITE:
          send_tick(make_tick($urandom, $urandom, 1'b1, 1'b1));
        default:
          send_tick(make_tick($urandom, $urandom, 1'b0, 1'b0));
      endcase
    end
    start = $urandom;
    send_tick(make_tick(start + 32'd3, start, 1'b1, 1'b1));
    send_tick(make_tick(mark_ms, start, 1'b1, 1'b0));
    send_tick(make_tick($urandom, $urandom, 1'b1, 1'b1));
    repeat (3) send_tick(make_tick(start + 32'd10, start, 1'b1, 1'b1));
  endtask

  function automatic string fmt_beat(input result_t r);
    return $sformatf("phase=%0d blink=%0d err=%0b cal=%0b ch=%0d black=%03h white=%03h last=%0b",
                     r.phase, r.blink, r.err, r.cal, r.channel, r.black, r.white, r.last);
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      got.phase   = phase_t'(res_bus.phase);
      got.blink   = blink_t'(res_bus.blink_mode);
      got.err     = res_bus.stuck_error;
      got.cal     = res_bus.cal_valid;
      got.channel = res_bus.channel;
      got.black   = res_bus.black_level;
      got.white   = res_bus.white_level;
      got.last    = res_bus.last;
      if (beats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected beat %s", $time, fmt_beat(got));
      end else begin
        want = beats_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch\n  expected %s\n  actual   %s", $time, fmt_beat(want),
                     fmt_beat(got));
        end
      end
    end
  end

  initial begin
    res_bus.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idling_on && $urandom_range(0, 4) == 0) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        res_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_LONG_PRESS;
    cfg_data  <= '0;
    tick_bus.valid          <= 1'b0;
    tick_bus.now_ms         <= '0;
    tick_bus.press_start_ms <= '0;
    tick_bus.key_down       <= 1'b0;
    tick_bus.press_event    <= 1'b0;
    tick_bus.sample_ch0     <= '0;
    tick_bus.sample_ch1     <= '0;
    tick_bus.sample_ch2     <= '0;
    tick_bus.sample_ch3     <= '0;
    tick_bus.sample_ch4     <= '0;
    tick_bus.sample_ch5     <= '0;
    tick_bus.sample_ch6     <= '0;
    tick_bus.sample_ch7     <= '0;
    cur_phase  = PH_IDLE;
    cur_blink  = BL_OFF;
    stuck_flag = 1'b0;
    pend_press = 1'b0;
    mark_ms    = '0;
    long_ms    = LONG_PRESS_RST;
    hold_ms    = MAX_HOLD_RST;
    confirm_ms = CONFIRM_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed_calibration();
    test_random_sequences(110, 16'd0, 16'hFFFF, 16'd0);
    test_random_sequences(110, 16'($urandom_range(1, 40)), 16'($urandom_range(50, 5000)),
                          16'($urandom_range(1, 30)));
    test_random_sequences(110, 16'hFFFF, 16'($urandom_range(1, 100)), 16'hFFFF);
    // The closing part runs with both sides streaming.
    idling_on = 1'b0;
    test_random_sequences(110, 16'($urandom), 16'($urandom), 16'($urandom));
    test_stuck_key();
    wait_drained();

    mismatches += beats_due.size();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* button_calibration_sequencer_unit.f */
hw/rtl/bcs_pkg.sv
hw/rtl/bcs_in_if.sv
hw/rtl/bcs_out_if.sv
hw/rtl/bcs_ctrl.sv
hw/rtl/bcs_dp.sv
hw/rtl/button_calibration_sequencer_unit.sv
dv/tb_button_calibration_sequencer_unit.sv
